// ===== rtl/core/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg: shared types, constants and helpers for the Mandelbrot pixel shader
// Fixed-point widths, register indexes, channel structs and FSM encodings.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int FRAC_BITS   = 28;
    localparam int COORD_BITS  = 12;
    localparam int ITER_BITS   = 12;

    localparam int CFG_W       = 32;
    localparam int STEP_W      = 28;
    localparam int IDX_W       = 3;

    // signed Q4 component width
    localparam int QW          = FRAC_BITS + 4;
    // pixel index times step, and the sum with the origin
    localparam int PROD_W      = COORD_BITS + STEP_W;
    localparam int SUM_W       = PROD_W + 2;
    // full product of two component magnitudes
    localparam int SQ_W        = 2 * QW;
    // working width of the z update: square plus cross term plus c
    localparam int WORK_W      = SQ_W - FRAC_BITS + 3;
    localparam int SAT_IN_W    = ((SUM_W > WORK_W) ? SUM_W : WORK_W) + 1;

    localparam int SHADE_W     = 8;
    localparam int SHADE_BIT_W = $clog2(SHADE_W);
    localparam int NUM_W       = ITER_BITS + SHADE_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [WORK_W-1:0] FOUR_Q       = WORK_W'(4) << FRAC_BITS;
    localparam logic [7:0]        ALPHA_OPAQUE = 8'hFF;
    localparam logic [31:0]       OPAQUE_BLACK = 32'hFF00_0000;

    localparam logic [CFG_W-1:0]     RST_LEFT_REAL = 32'hE400_0000;
    localparam logic [CFG_W-1:0]     RST_TOP_IMAG  = 32'hF060_0000;
    localparam logic [STEP_W-1:0]    RST_STEP_REAL = 28'd671088;
    localparam logic [STEP_W-1:0]    RST_STEP_IMAG = 28'd820025;
    localparam logic [ITER_BITS-1:0] RST_MAX_ITERS = 12'd256;

    typedef enum logic [IDX_W-1:0] {
        IDX_LEFT_REAL = 3'd0,
        IDX_TOP_IMAG  = 3'd1,
        IDX_STEP_REAL = 3'd2,
        IDX_STEP_IMAG = 3'd3,
        IDX_MAX_ITERS = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [CFG_W-1:0] left_real;
        logic signed [CFG_W-1:0] top_imag;
        logic [STEP_W-1:0]       step_real;
        logic [STEP_W-1:0]       step_imag;
        logic [ITER_BITS-1:0]    max_iters;
    } cfg_t;

    typedef struct packed {
        logic signed [QW-1:0] cr;
        logic signed [QW-1:0] ci;
    } point_t;

    typedef struct packed {
        logic [ITER_BITS-1:0] iter;
        logic                 in_set;
    } esc_t;

    typedef enum logic [1:0] {
        IT_IDLE,
        IT_MUL,
        IT_ADD,
        IT_DONE
    } iter_state_t;

    typedef enum logic [1:0] {
        SH_IDLE,
        SH_DIV,
        SH_OUT
    } shade_state_t;

    // clamp a wide signed value into the Q4 component range
    function automatic logic signed [QW-1:0] sat_q(input logic signed [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-QW:0] hi_bits;
        hi_bits = v[SAT_IN_W-1:QW-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            sat_q = v[QW-1:0];
        end else if (v[SAT_IN_W-1]) begin
            sat_q = {1'b1, {(QW-1){1'b0}}};
        end else begin
            sat_q = {1'b0, {(QW-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/core/mps_front.sv =====
// ----------------------------------------------------------------------------
// mps_front: pixel coordinate to complex point
// Two stages: scale the indices by the steps, then add the origin and clamp.
// ----------------------------------------------------------------------------
module mps_front import mps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_pixel_col,
    input  logic [COORD_BITS-1:0] s_pixel_row,
    output logic                  pt_valid,
    input  logic                  pt_ready,
    output point_t                pt
);

    logic              v1_reg;
    logic              v2_reg;
    logic [PROD_W-1:0] prod_re_reg;
    logic [PROD_W-1:0] prod_im_reg;
    point_t            pt_reg;

    logic              adv1;
    logic              adv2;
    logic [PROD_W-1:0] prod_re;
    logic [PROD_W-1:0] prod_im;
    logic [SUM_W-1:0]  sum_re;
    logic [SUM_W-1:0]  sum_im;

    assign adv2     = !v2_reg || pt_ready;
    assign adv1     = !v1_reg || adv2;
    assign s_ready  = adv1;
    assign pt_valid = v2_reg;
    assign pt       = pt_reg;

    assign prod_re = PROD_W'(s_pixel_col) * PROD_W'(cfg.step_real);
    assign prod_im = PROD_W'(s_pixel_row) * PROD_W'(cfg.step_imag);

    assign sum_re = {{(SUM_W-CFG_W){cfg.left_real[CFG_W-1]}}, cfg.left_real}
                  + {2'b00, prod_re_reg};
    assign sum_im = {{(SUM_W-CFG_W){cfg.top_imag[CFG_W-1]}}, cfg.top_imag}
                  + {2'b00, prod_im_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            prod_re_reg <= prod_re;
            prod_im_reg <= prod_im;
        end
        if (adv2 && v1_reg) begin
            pt_reg.cr <= sat_q({{(SAT_IN_W-SUM_W){sum_re[SUM_W-1]}}, sum_re});
            pt_reg.ci <= sat_q({{(SAT_IN_W-SUM_W){sum_im[SUM_W-1]}}, sum_im});
        end
    end

endmodule

// ===== rtl/core/mps_queue.sv =====
// ----------------------------------------------------------------------------
// mps_queue: short point queue between front and back
// Lets the coordinate front run ahead while the iteration engine is busy.
// ----------------------------------------------------------------------------
module mps_queue import mps_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  point_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output point_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    point_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/mps_iter.sv =====
// ----------------------------------------------------------------------------
// mps_iter: escape-time iteration engine
// Each z = z*z + c step runs as a multiply state, then an add, test and clamp state.
// ----------------------------------------------------------------------------
module mps_iter import mps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [ITER_BITS-1:0] max_iters,
    input  logic                 pt_valid,
    output logic                 pt_ready,
    input  point_t               pt,
    output logic                 res_valid,
    input  logic                 res_ready,
    output esc_t                 res
);

    localparam int SQ_SH_W = SQ_W - FRAC_BITS;
    localparam int XY_SH_W = SQ_W - FRAC_BITS + 1;

    iter_state_t          state_reg;
    iter_state_t          state_next;
    logic signed [QW-1:0] cr_reg;
    logic signed [QW-1:0] ci_reg;
    logic signed [QW-1:0] x_reg;
    logic signed [QW-1:0] y_reg;
    logic [ITER_BITS-1:0] iter_reg;
    logic                 in_set_reg;
    logic [SQ_W-1:0]      pxx_reg;
    logic [SQ_W-1:0]      pyy_reg;
    logic [SQ_W-1:0]      pxy_reg;
    logic                 xy_neg_reg;

    logic [QW-1:0]        mag_x;
    logic [QW-1:0]        mag_y;
    logic [SQ_W-1:0]      sq_xx;
    logic [SQ_W-1:0]      sq_yy;
    logic [SQ_W-1:0]      sq_xy;
    logic [WORK_W-1:0]    x2_w;
    logic [WORK_W-1:0]    y2_w;
    logic [WORK_W-1:0]    xy_w;
    logic [WORK_W-1:0]    xy_s;
    logic [WORK_W-1:0]    cr_w;
    logic [WORK_W-1:0]    ci_w;
    logic [WORK_W-1:0]    mag_sum;
    logic [WORK_W-1:0]    new_x;
    logic [WORK_W-1:0]    new_y;
    logic                 escape;
    logic [ITER_BITS-1:0] iter_inc;
    logic                 at_limit;
    logic                 take;

    assign mag_x = x_reg[QW-1] ? QW'(-x_reg) : x_reg;
    assign mag_y = y_reg[QW-1] ? QW'(-y_reg) : y_reg;
    assign sq_xx = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_yy = SQ_W'(mag_y) * SQ_W'(mag_y);
    assign sq_xy = SQ_W'(mag_x) * SQ_W'(mag_y);

    // truncate magnitudes, then restore the sign of the cross term
    assign x2_w = {{(WORK_W-SQ_SH_W){1'b0}}, pxx_reg[SQ_W-1:FRAC_BITS]};
    assign y2_w = {{(WORK_W-SQ_SH_W){1'b0}}, pyy_reg[SQ_W-1:FRAC_BITS]};
    assign xy_w = {{(WORK_W-XY_SH_W){1'b0}}, pxy_reg[SQ_W-1:FRAC_BITS-1]};
    assign xy_s = xy_neg_reg ? WORK_W'(-xy_w) : xy_w;
    assign cr_w = {{(WORK_W-QW){cr_reg[QW-1]}}, cr_reg};
    assign ci_w = {{(WORK_W-QW){ci_reg[QW-1]}}, ci_reg};

    assign mag_sum  = x2_w + y2_w;
    assign escape   = mag_sum > FOUR_Q;
    assign new_x    = x2_w - y2_w + cr_w;
    assign new_y    = xy_s + ci_w;
    assign iter_inc = iter_reg + 1'b1;
    assign at_limit = iter_inc == max_iters;

    assign take      = pt_valid && pt_ready;
    assign res.iter   = iter_reg;
    assign res.in_set = in_set_reg;

    always_comb begin
        state_next = state_reg;
        pt_ready   = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            IT_IDLE: begin
                pt_ready = 1'b1;
                if (pt_valid) begin
                    state_next = (max_iters == '0) ? IT_DONE : IT_MUL;
                end
            end
            IT_MUL: begin
                state_next = IT_ADD;
            end
            IT_ADD: begin
                state_next = (escape || at_limit) ? IT_DONE : IT_MUL;
            end
            IT_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = IT_IDLE;
                end
            end
            default: begin
                state_next = IT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cr_reg     <= pt.cr;
            ci_reg     <= pt.ci;
            x_reg      <= '0;
            y_reg      <= '0;
            iter_reg   <= '0;
            in_set_reg <= max_iters == '0;
        end
        if (state_reg == IT_MUL) begin
            pxx_reg    <= sq_xx;
            pyy_reg    <= sq_yy;
            pxy_reg    <= sq_xy;
            xy_neg_reg <= x_reg[QW-1] ^ y_reg[QW-1];
        end
        if (state_reg == IT_ADD) begin
            if (escape) begin
                in_set_reg <= 1'b0;
            end else begin
                x_reg      <= sat_q({{(SAT_IN_W-WORK_W){new_x[WORK_W-1]}}, new_x});
                y_reg      <= sat_q({{(SAT_IN_W-WORK_W){new_y[WORK_W-1]}}, new_y});
                iter_reg   <= iter_inc;
                in_set_reg <= at_limit;
            end
        end
    end

endmodule

// ===== rtl/core/mps_shade.sv =====
// ----------------------------------------------------------------------------
// mps_shade: iteration count to ARGB colour, with output register
// Restoring divide of iter*255 by the limit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mps_shade import mps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [ITER_BITS-1:0] max_iters,
    input  logic                 res_valid,
    output logic                 res_ready,
    input  esc_t                 res,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_argb_color,
    output logic [ITER_BITS-1:0] m_iter_count,
    output logic                 m_in_set
);

    shade_state_t           state_reg;
    shade_state_t           state_next;
    logic [NUM_W-1:0]       rem_reg;
    logic [SHADE_W-1:0]     quo_reg;
    logic [SHADE_BIT_W-1:0] bit_reg;
    logic [ITER_BITS-1:0]   iter_reg;
    logic                   in_set_reg;
    logic [31:0]            color_reg;

    logic                   take;
    logic [NUM_W-1:0]       trial;
    logic                   fits;
    logic [SHADE_W-1:0]     quo_fin;
    logic [SHADE_W+2:0]     g_sum;

    assign take  = res_valid && res_ready;
    assign trial = NUM_W'(max_iters) << bit_reg;
    assign fits  = rem_reg >= trial;
    assign g_sum = {3'b000, quo_fin} + {1'b0, quo_fin, 2'b00};

    always_comb begin
        quo_fin          = quo_reg;
        quo_fin[bit_reg] = fits;
    end

    assign m_argb_color = color_reg;
    assign m_iter_count = iter_reg;
    assign m_in_set     = in_set_reg;

    always_comb begin
        state_next = state_reg;
        res_ready  = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            SH_IDLE: begin
                res_ready = 1'b1;
                if (res_valid) begin
                    state_next = res.in_set ? SH_OUT : SH_DIV;
                end
            end
            SH_DIV: begin
                if (bit_reg == '0) begin
                    state_next = SH_OUT;
                end
            end
            SH_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = SH_IDLE;
                end
            end
            default: begin
                state_next = SH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SH_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            iter_reg   <= res.iter;
            in_set_reg <= res.in_set;
            rem_reg    <= {res.iter, {SHADE_W{1'b0}}} - NUM_W'(res.iter);
            quo_reg    <= '0;
            bit_reg    <= SHADE_BIT_W'(SHADE_W - 1);
            if (res.in_set) begin
                color_reg <= OPAQUE_BLACK;
            end
        end
        if (state_reg == SH_DIV) begin
            if (fits) begin
                rem_reg <= rem_reg - trial;
            end
            quo_reg <= quo_fin;
            bit_reg <= bit_reg - 1'b1;
            if (bit_reg == '0) begin
                color_reg <= {ALPHA_OPAQUE, quo_fin, g_sum[SHADE_W+2:3], ~quo_fin};
            end
        end
    end

endmodule

// ===== rtl/core/mandelbrot_pixel_shader.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_shader: escape-time colour for one pixel per input beat
//
// Input beat (s_valid/s_ready): pixel column and row. The front maps it to a
// point c = origin + index * step in signed Q4.28 and clamps it, then queues
// it for the iteration engine, which runs z = z*z + c from zero until |z|^2
// exceeds 4 or the count reaches max_iters. The shader divides the count
// into a colour and holds the result beat (m_valid/m_ready) with the count and
// the in-set flag.
// Config beat (cfg_valid/cfg_ready, always ready): cfg_index 0..4 selects
// left_real, top_imag, step_real, step_imag, max_iters; other indexes are
// dropped. Write only while no pixel is in flight.
// One pixel is iterated at a time (a multiply step, then an add/test step per
// iteration). The divide and hand-off of an escaped colour overlaps with the
// iterations of the next pixel.
// Reset loads the default view and empties every stage. When the receiver
// stalls the result holds, the engine waits on its finished pixel, the queue
// fills and s_ready drops.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_shader import mps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_pixel_col,
    input  logic [COORD_BITS-1:0] s_pixel_row,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_argb_color,
    output logic [ITER_BITS-1:0]  m_iter_count,
    output logic                  m_in_set,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cfg_t   cfg_reg;
    logic   fq_valid;
    logic   fq_ready;
    point_t fq_data;
    logic   qi_valid;
    logic   qi_ready;
    point_t qi_data;
    logic   is_valid;
    logic   is_ready;
    esc_t   is_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_real <= RST_LEFT_REAL;
            cfg_reg.top_imag  <= RST_TOP_IMAG;
            cfg_reg.step_real <= RST_STEP_REAL;
            cfg_reg.step_imag <= RST_STEP_IMAG;
            cfg_reg.max_iters <= RST_MAX_ITERS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                IDX_LEFT_REAL: cfg_reg.left_real <= cfg_data;
                IDX_TOP_IMAG:  cfg_reg.top_imag  <= cfg_data;
                IDX_STEP_REAL: cfg_reg.step_real <= cfg_data[STEP_W-1:0];
                IDX_STEP_IMAG: cfg_reg.step_imag <= cfg_data[STEP_W-1:0];
                IDX_MAX_ITERS: cfg_reg.max_iters <= cfg_data[ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_col (s_pixel_col),
        .s_pixel_row (s_pixel_row),
        .pt_valid    (fq_valid),
        .pt_ready    (fq_ready),
        .pt          (fq_data)
    );

    mps_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qi_valid),
        .rd_ready (qi_ready),
        .rd_data  (qi_data)
    );

    mps_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_iters (cfg_reg.max_iters),
        .pt_valid  (qi_valid),
        .pt_ready  (qi_ready),
        .pt        (qi_data),
        .res_valid (is_valid),
        .res_ready (is_ready),
        .res       (is_data)
    );

    mps_shade u_shade (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .max_iters    (cfg_reg.max_iters),
        .res_valid    (is_valid),
        .res_ready    (is_ready),
        .res          (is_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_argb_color (m_argb_color),
        .m_iter_count (m_iter_count),
        .m_in_set     (m_in_set)
    );

endmodule

// ===== rtl/core/mps_monitor.sv =====
// ----------------------------------------------------------------------------
// mps_monitor: port-level checks for the Mandelbrot pixel shader
// Result channel behaviour after reset and colour coding against the flags.
// ----------------------------------------------------------------------------
module mps_monitor import mps_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [31:0]          m_argb_color,
    input logic [ITER_BITS-1:0] m_iter_count,
    input logic                 m_in_set
);

    logic [7:0]  red;
    logic [10:0] g_sum;

    assign red   = m_argb_color[23:16];
    assign g_sum = {3'b000, red} + {1'b0, red, 2'b00};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat shown straight after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_argb_color)
            && $stable(m_iter_count) && $stable(m_in_set))
        else $error("stalled result beat changed");

    a_in_set_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_set |-> m_argb_color == OPAQUE_BLACK)
        else $error("in-set pixel is not opaque black");

    a_shade_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_set |-> m_argb_color[31:24] == ALPHA_OPAQUE
            && m_argb_color[7:0] == ~red && m_argb_color[15:8] == g_sum[10:3])
        else $error("escaped pixel colour channels inconsistent");

    a_zero_iter_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_set && m_iter_count == '0 |-> red == 8'd0)
        else $error("immediate escape gave non-zero shade");

endmodule

bind mandelbrot_pixel_shader mps_monitor u_mps_monitor (.*);

// ===== tb/mps_shade_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_shade_checker: result checker for the Mandelbrot pixel shader
// Tracks every register write, predicts the escape count and colour of each
// accepted pixel beat and compares each result beat with the oldest pending
// prediction. Hands the mismatch count and the number of outstanding pixels
// to the testbench top.
// ----------------------------------------------------------------------------
module mps_shade_checker import mps_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_pixel_col,
    input  logic [COORD_BITS-1:0] s_pixel_row,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [31:0]           m_argb_color,
    input  logic [ITER_BITS-1:0]  m_iter_count,
    input  logic                  m_in_set,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    shade_errors,
    output int                    shades_in_flight
);

    typedef struct packed {
        logic [31:0]          argb;
        logic [ITER_BITS-1:0] iters;
        logic                 in_set;
    } shade_t;

    localparam longint Q_HI = (longint'(1) << (QW - 1)) - 1;
    localparam longint Q_LO = -(longint'(1) << (QW - 1));
    localparam longint ESCAPE_RADIUS_SQ = longint'(4) << FRAC_BITS;

    cfg_t   view;
    shade_t expected_shades[$];

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI) begin
            return Q_HI;
        end
        if (v < Q_LO) begin
            return Q_LO;
        end
        return v;
    endfunction

    // product shifted right, magnitude truncated toward zero
    function automatic longint trunc_mul(input longint a, input longint b, input int sh);
        longint ma;
        longint mb;
        longint q;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q  = (ma * mb) >>> sh;
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function automatic shade_t escape_shade(input logic [COORD_BITS-1:0] col,
                                            input logic [COORD_BITS-1:0] row);
        longint cr;
        longint ci;
        longint x;
        longint y;
        longint x2;
        longint y2;
        longint xy2;
        int     iters;
        int     limit;
        int     shade;
        int     green;
        bit     escaped;
        shade_t res;
        cr = clamp_q(longint'($signed(view.left_real))
                     + longint'(col) * longint'(view.step_real));
        ci = clamp_q(longint'($signed(view.top_imag))
                     + longint'(row) * longint'(view.step_imag));
        limit   = int'(view.max_iters);
        iters   = 0;
        escaped = 1'b0;
        x = 0;
        y = 0;
        while (iters < limit && !escaped) begin
            x2 = trunc_mul(x, x, FRAC_BITS);
            y2 = trunc_mul(y, y, FRAC_BITS);
            if (x2 + y2 > ESCAPE_RADIUS_SQ) begin
                escaped = 1'b1;
            end else begin
                xy2 = trunc_mul(x, y, FRAC_BITS - 1);
                x = clamp_q(x2 - y2 + cr);
                y = clamp_q(xy2 + ci);
                iters++;
            end
        end
        res.iters  = ITER_BITS'(iters);
        res.in_set = (iters >= limit);
        if (res.in_set) begin
            res.argb = OPAQUE_BLACK;
        end else begin
            shade = iters * 255 / limit;
            green = (shade * 5) >> 3;
            res.argb = {ALPHA_OPAQUE, 8'(shade), 8'(green), 8'(255 - shade)};
        end
        return res;
    endfunction

    always @(posedge aclk) begin : track
        shade_t got;
        shade_t want;
        if (!aresetn) begin
            view.left_real = RST_LEFT_REAL;
            view.top_imag  = RST_TOP_IMAG;
            view.step_real = RST_STEP_REAL;
            view.step_imag = RST_STEP_IMAG;
            view.max_iters = RST_MAX_ITERS;
            expected_shades.delete();
            shade_errors     = 0;
            shades_in_flight = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    IDX_LEFT_REAL: view.left_real = cfg_data;
                    IDX_TOP_IMAG:  view.top_imag  = cfg_data;
                    IDX_STEP_REAL: view.step_real = cfg_data[STEP_W-1:0];
                    IDX_STEP_IMAG: view.step_imag = cfg_data[STEP_W-1:0];
                    IDX_MAX_ITERS: view.max_iters = cfg_data[ITER_BITS-1:0];
                    default: ;  // drop writes to unmapped indexes
                endcase
            end
            if (s_valid && s_ready) begin
                expected_shades.push_back(escape_shade(s_pixel_col, s_pixel_row));
            end
            if (m_valid && m_ready) begin
                got.argb   = m_argb_color;
                got.iters  = m_iter_count;
                got.in_set = m_in_set;
                if (expected_shades.size() == 0) begin
                    $display("%0t: unexpected result beat: argb %h iter %0d in_set %b",
                             $time, got.argb, got.iters, got.in_set);
                    shade_errors++;
                end else begin
                    want = expected_shades.pop_front();
                    if (got.argb != want.argb || got.iters != want.iters ||
                        got.in_set != want.in_set) begin
                        $display("%0t: pixel mismatch: expected argb %h iter %0d in_set %b",
                                 $time, want.argb, want.iters, want.in_set,
                                 ", actual argb %h iter %0d in_set %b",
                                 got.argb, got.iters, got.in_set);
                        shade_errors++;
                    end
                end
            end
            shades_in_flight = expected_shades.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Mandelbrot pixel shader
// Drives pixel beats in random bursts with random back-pressure on results,
// reprograms the view between phases (extreme origins and steps, zero and
// maximum iteration limits, unmapped indexes) and reports the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    import mps_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 32;
    localparam int TARGET_PIXELS  = 2000;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int JUNK_IDX_LO    = int'(IDX_MAX_ITERS) + 1;
    localparam int JUNK_IDX_HI    = (1 << IDX_W) - 1;

    // Q4.28 view constants
    localparam longint WIDE_SPAN_RE = 858993459;   // 3.2
    localparam longint WIDE_SPAN_IM = 590558003;   // 2.2
    localparam longint ZOOM_RE      = -199990723;  // -0.745
    localparam longint ZOOM_IM      = 32212255;    // 0.120
    localparam longint FULL_LEFT    = -536870912;  // -2.0

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_pixel_col = '0;
    logic [COORD_BITS-1:0] s_pixel_row = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [31:0]           m_argb_color;
    logic [ITER_BITS-1:0]  m_iter_count;
    logic                  m_in_set;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index   = '0;
    logic [CFG_W-1:0]      cfg_data    = '0;

    int shade_errors;
    int shades_in_flight;
    int burst_left   = 0;
    int stall_mode   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    mandelbrot_pixel_shader u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_col  (s_pixel_col),
        .s_pixel_row  (s_pixel_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_argb_color (m_argb_color),
        .m_iter_count (m_iter_count),
        .m_in_set     (m_in_set),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mps_shade_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel_col      (s_pixel_col),
        .s_pixel_row      (s_pixel_row),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_argb_color     (m_argb_color),
        .m_iter_count     (m_iter_count),
        .m_in_set         (m_in_set),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .shade_errors     (shade_errors),
        .shades_in_flight (shades_in_flight)
    );

    // receiver: free-running, coin-toss and mostly-stalled stretches
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 400);
        end
        stall_left--;
        case (stall_mode)
            0, 3:    m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_pixel(input logic [COORD_BITS-1:0] col,
                               input logic [COORD_BITS-1:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 3);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_pixel_col <= col;
        s_pixel_row <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drain the pipeline, then reprogram every register
    task automatic set_view(input logic [CFG_W-1:0] left, input logic [CFG_W-1:0] top,
                            input logic [CFG_W-1:0] step_re, input logic [CFG_W-1:0] step_im,
                            input logic [CFG_W-1:0] limit, input int junk_writes);
        s_valid <= 1'b0;
        while (shades_in_flight != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        repeat (junk_writes) begin
            reg_write(IDX_W'($urandom_range(JUNK_IDX_LO, JUNK_IDX_HI)), $urandom);
        end
        reg_write(IDX_LEFT_REAL, left);
        reg_write(IDX_TOP_IMAG, top);
        reg_write(IDX_STEP_REAL, step_re);
        reg_write(IDX_STEP_IMAG, step_im);
        reg_write(IDX_MAX_ITERS, limit);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int     sent;
        int     batch;
        int     view_kind;
        int     frame_w;
        int     frame_h;
        int     zoom;
        longint step_re;
        longint step_im;
        longint left;
        longint top;
        int     limit;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default view: corners, points on the real axis deep in the set, cusp
        drive_pixel(0, 0);
        drive_pixel(4095, 4095);
        drive_pixel(0, 4095);
        drive_pixel(4095, 0);
        drive_pixel(700, 400);
        drive_pixel(700, 320);
        drive_pixel(500, 320);
        drive_pixel(100, 320);
        drive_pixel(800, 320);

        // origin at the positive and negative limits, widest steps (upper bits dropped)
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1);
        drive_pixel(0, 0);
        drive_pixel(4095, 4095);
        drive_pixel(2048, 1);

        set_view(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1, 0);
        drive_pixel(0, 0);
        drive_pixel(4095, 4095);

        // c = 0 runs the full maximum limit
        set_view(0, 0, 0, 0, (1 << ITER_BITS) - 1, 3);
        drive_pixel(0, 0);
        drive_pixel(4095, 4095);

        // zero limit: no iteration at all
        set_view(RST_LEFT_REAL, RST_TOP_IMAG, CFG_W'(RST_STEP_REAL), CFG_W'(RST_STEP_IMAG),
                 0, 0);
        drive_pixel(0, 0);
        drive_pixel(700, 320);
        drive_pixel(4095, 4095);

        sent = 0;
        while (sent < TARGET_PIXELS) begin
            view_kind = $urandom_range(0, 9);
            batch = $urandom_range(100, 200);
            frame_w = $urandom_range(16, 600);
            frame_h = $urandom_range(16, 600);
            limit = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 300)
                                                : $urandom_range(1, 96);
            if (view_kind == 0) begin
                // any origin and steps the registers can hold
                frame_w = 1 << COORD_BITS;
                frame_h = 1 << COORD_BITS;
                left    = longint'($urandom);
                top     = longint'($urandom);
                step_re = longint'($urandom);
                step_im = longint'($urandom);
                limit   = $urandom_range(0, 64);
            end else if (view_kind == 9) begin
                frame_w = 1300;
                frame_h = 660;
                left    = longint'($signed(RST_LEFT_REAL));
                top     = longint'($signed(RST_TOP_IMAG));
                step_re = longint'(RST_STEP_REAL);
                step_im = longint'(RST_STEP_IMAG);
                limit   = $urandom_range(255, 256);
            end else begin
                zoom    = $urandom_range(1, 4);
                step_re = WIDE_SPAN_RE / (frame_w * zoom);
                step_im = WIDE_SPAN_IM / (frame_h * zoom);
                if (zoom == 1) begin
                    left = FULL_LEFT;
                    top  = -(WIDE_SPAN_IM / 2);
                end else begin
                    left = ZOOM_RE - step_re * frame_w / 2;
                    top  = ZOOM_IM - step_im * frame_h / 2;
                end
            end
            set_view(CFG_W'(left), CFG_W'(top), CFG_W'(step_re), CFG_W'(step_im),
                     CFG_W'(limit), $urandom_range(0, 1));
            repeat (batch) begin
                if ($urandom_range(0, 4) != 0) begin
                    col = COORD_BITS'($urandom_range(0, frame_w - 1));
                    row = COORD_BITS'($urandom_range(0, frame_h - 1));
                end else begin
                    col = COORD_BITS'($urandom);
                    row = COORD_BITS'($urandom);
                end
                drive_pixel(col, row);
            end
            sent += batch;
        end

        s_valid <= 1'b0;
        while (shades_in_flight != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (shade_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
